### src/ccs_pkg.sv
// Shared types, operation codes and digit helpers for the chiming clock.
// No dependencies; used by clock_with_chime_and_segment_scan and the bench.
package ccs_pkg;

    // Operation codes of an input beat
    localparam logic [2:0] OP_SECOND_TICK = 3'd0;
    localparam logic [2:0] OP_SCAN_TICK   = 3'd1;
    localparam logic [2:0] OP_PAUSE       = 3'd2;
    localparam logic [2:0] OP_SET_TIME    = 3'd3;
    localparam logic [2:0] OP_TOGGLE_MODE = 3'd4;

    // Set-time error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_HOURS   = 2'd1;
    localparam logic [1:0] ERR_MINUTES = 2'd2;
    localparam logic [1:0] ERR_SECONDS = 2'd3;

    // Digit code of the C glyph
    localparam logic [3:0] GLYPH_C = 4'd12;

    // Clock limits
    localparam logic [4:0] MAX_HOUR   = 5'd23;
    localparam logic [5:0] MAX_MINUTE = 6'd59;
    localparam logic [5:0] MAX_SECOND = 6'd59;
    localparam logic [4:0] NOON_HOUR  = 5'd12;
    localparam logic [4:0] MIDNIGHT_CHIMES = 5'd24;

    // Colon / decimal point bit
    localparam logic [7:0] SEG_DOT = 8'h80;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         new_hours;
        logic [6:0]         new_minutes;
        logic [6:0]         new_seconds;
        logic signed [11:0] temperature_tenths;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_select;
        logic       led_on;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] set_error;
        logic       show_temperature;
        logic       paused;
    } out_beat_t;

    // Seven-segment pattern of a hex digit code
    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h5F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h3B;
            4'd3:    p = 8'h2F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            4'd10:   p = 8'h77;
            4'd11:   p = 8'h7C;
            4'd12:   p = 8'h59;
            4'd13:   p = 8'h3E;
            4'd14:   p = 8'h79;
            default: p = 8'h71;
        endcase
        return p;
    endfunction

    // Tens digit of a value below 64: multiply by 205/2048
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd205;
        return {1'b0, p[13:11]};
    endfunction

    // Ones digit of a value below 64
    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - 6'(tens_of(v)) * 6'd10;
        return r[3:0];
    endfunction

endpackage

### src/ccs_temp_digits.sv
// Temperature clamp to 0..999 tenths and split into three decimal digits.
// No dependencies; purely combinational.
module ccs_temp_digits (
    input  logic signed [11:0] temperature_tenths,
    output logic [3:0]         tenths_digit,
    output logic [3:0]         ones_digit,
    output logic [3:0]         tens_digit
);

    logic [9:0]  clamped;
    logic [17:0] prod_10;
    logic [15:0] prod_100;
    logic [6:0]  quot_10;
    logic [3:0]  quot_100;
    logic [9:0]  rem_10;
    logic [6:0]  rem_100;

    // Saturate to 0..999
    always_comb begin
        if (temperature_tenths < 12'sd0) begin
            clamped = 10'd0;
        end else if (temperature_tenths > 12'sd999) begin
            clamped = 10'd999;
        end else begin
            clamped = temperature_tenths[9:0];
        end
    end

    // Reciprocal multiplies: exact for 0..999
    always_comb begin
        prod_10      = 18'(clamped) * 18'd205;
        quot_10      = prod_10[17:11];
        prod_100     = 16'(clamped) * 16'd41;
        quot_100     = prod_100[15:12];
        rem_10       = clamped - 10'(quot_10) * 10'd10;
        rem_100      = quot_10 - 7'(quot_100) * 7'd10;
        tenths_digit = rem_10[3:0];
        ones_digit   = rem_100[3:0];
        tens_digit   = quot_100;
    end

endmodule

### src/clock_with_chime_and_segment_scan.sv
// Beats pass the input register, then the result register; all work is one pass of logic
// between them. Throughput: one beat per cycle unless m_ready stalls the output.
// Reset (aresetn low, synchronous): clock 11:59:50, running, time display, chime idle,
// LED off, scan slot 0, shown time and temperature digits zero, both stages empty.
// Uses ccs_pkg and ccs_temp_digits.
module clock_with_chime_and_segment_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ccs_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ccs_pkg::out_beat_t m_data
);

    // Pipeline handshake registers
    logic               in_valid_reg;
    ccs_pkg::in_beat_t  in_data_reg;
    logic               m_valid_reg;
    ccs_pkg::out_beat_t m_data_reg;
    logic               out_ready;
    logic               step;

    // Clock state
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [4:0] shown_hour_reg, shown_hour_next;
    logic [5:0] shown_minute_reg, shown_minute_next;
    logic [3:0] temp_digit_reg [4];
    logic [3:0] temp_digit_next [4];
    logic [4:0] chime_reg, chime_next;
    logic       led_reg, led_next;
    logic [1:0] scan_reg, scan_next;
    logic       mode_reg, mode_next;
    logic       pause_reg, pause_next;

    ccs_pkg::out_beat_t result;

    logic [3:0] t_tenths, t_ones, t_tens;
    logic [3:0] digit;
    logic       load_temp;
    logic [4:0] hour_inc;

    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign step      = in_valid_reg && out_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    ccs_temp_digits u_temp (
        .temperature_tenths (in_data_reg.temperature_tenths),
        .tenths_digit       (t_tenths),
        .ones_digit         (t_ones),
        .tens_digit         (t_tens)
    );

    // Next state and result of the registered beat
    always_comb begin
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        second_next       = second_reg;
        shown_hour_next   = shown_hour_reg;
        shown_minute_next = shown_minute_reg;
        for (int i = 0; i < 4; i++) begin
            temp_digit_next[i] = temp_digit_reg[i];
        end
        chime_next = chime_reg;
        led_next   = led_reg;
        scan_next  = scan_reg;
        mode_next  = mode_reg;
        pause_next = pause_reg;
        load_temp  = 1'b0;
        hour_inc   = 5'd0;
        digit      = 4'd0;
        result     = '0;

        case (in_data_reg.operation)
            ccs_pkg::OP_SECOND_TICK: begin
                if (!pause_reg) begin
                    if (second_reg >= ccs_pkg::MAX_SECOND) begin
                        second_next = 6'd0;
                        if (minute_reg >= ccs_pkg::MAX_MINUTE) begin
                            minute_next = 6'd0;
                            hour_inc = (hour_reg >= ccs_pkg::MAX_HOUR) ? 5'd0 : hour_reg + 5'd1;
                            hour_next = hour_inc;
                            // Arm chime: twice the hour in 12-hour form
                            if (hour_inc > ccs_pkg::NOON_HOUR) begin
                                chime_next = 5'((hour_inc - ccs_pkg::NOON_HOUR) << 1);
                            end else if (hour_inc == 5'd0) begin
                                chime_next = ccs_pkg::MIDNIGHT_CHIMES;
                            end else begin
                                chime_next = 5'(hour_inc << 1);
                            end
                        end else begin
                            minute_next = minute_reg + 6'd1;
                        end
                    end else begin
                        second_next = second_reg + 6'd1;
                    end
                    shown_hour_next   = hour_next;
                    shown_minute_next = minute_next;
                    load_temp         = mode_reg;
                end
                // Chime runs even while paused
                if (chime_next != 5'd0) begin
                    led_next   = !led_reg;
                    chime_next = chime_next - 5'd1;
                end
            end
            ccs_pkg::OP_SCAN_TICK: begin
                if (!mode_reg) begin
                    case (scan_reg)
                        2'd0:    digit = ccs_pkg::ones_of(shown_minute_reg);
                        2'd1:    digit = ccs_pkg::tens_of(shown_minute_reg);
                        2'd2:    digit = ccs_pkg::ones_of({1'b0, shown_hour_reg});
                        default: digit = ccs_pkg::tens_of({1'b0, shown_hour_reg});
                    endcase
                    result.segments = ccs_pkg::seg_pattern(digit);
                    // Colon blinks on even seconds
                    if (scan_reg == 2'd2 && !second_reg[0]) begin
                        result.segments = result.segments ^ ccs_pkg::SEG_DOT;
                    end
                end else begin
                    digit = temp_digit_reg[scan_reg];
                    result.segments = ccs_pkg::seg_pattern(digit);
                    if (scan_reg == 2'd3) begin
                        result.segments = result.segments | ccs_pkg::SEG_DOT;
                    end
                end
                result.digit_select = 4'b1000 >> scan_reg;
                scan_next = scan_reg + 2'd1;
            end
            ccs_pkg::OP_PAUSE: begin
                pause_next = 1'b1;
            end
            ccs_pkg::OP_SET_TIME: begin
                if (pause_reg) begin
                    hour_next   = 5'd0;
                    minute_next = 6'd0;
                    second_next = 6'd0;
                    if (in_data_reg.new_hours > 7'(ccs_pkg::MAX_HOUR)) begin
                        result.set_error = ccs_pkg::ERR_HOURS;
                    end else begin
                        hour_next = in_data_reg.new_hours[4:0];
                        if (in_data_reg.new_minutes > 7'(ccs_pkg::MAX_MINUTE)) begin
                            result.set_error = ccs_pkg::ERR_MINUTES;
                        end else begin
                            minute_next = in_data_reg.new_minutes[5:0];
                            if (in_data_reg.new_seconds > 7'(ccs_pkg::MAX_SECOND)) begin
                                result.set_error = ccs_pkg::ERR_SECONDS;
                            end else begin
                                second_next = in_data_reg.new_seconds[5:0];
                                pause_next  = 1'b0;
                            end
                        end
                    end
                end
            end
            ccs_pkg::OP_TOGGLE_MODE: begin
                mode_next = !mode_reg;
                load_temp = !mode_reg;
            end
            default: begin
            end
        endcase

        // Temperature digits, least significant slot first
        if (load_temp) begin
            temp_digit_next[0] = ccs_pkg::GLYPH_C;
            temp_digit_next[1] = t_tenths;
            temp_digit_next[2] = t_ones;
            temp_digit_next[3] = t_tens;
        end

        result.led_on           = led_next;
        result.hours            = hour_next;
        result.minutes          = minute_next;
        result.seconds          = second_next;
        result.show_temperature = mode_next;
        result.paused           = pause_next;
    end

    // Handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_ready) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            m_data_reg <= result;
        end
    end

    // Clock state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg         <= 5'd11;
            minute_reg       <= 6'd59;
            second_reg       <= 6'd50;
            shown_hour_reg   <= 5'd0;
            shown_minute_reg <= 6'd0;
            for (int i = 0; i < 4; i++) begin
                temp_digit_reg[i] <= 4'd0;
            end
            chime_reg <= 5'd0;
            led_reg   <= 1'b0;
            scan_reg  <= 2'd0;
            mode_reg  <= 1'b0;
            pause_reg <= 1'b0;
        end else if (step) begin
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
            second_reg       <= second_next;
            shown_hour_reg   <= shown_hour_next;
            shown_minute_reg <= shown_minute_next;
            for (int i = 0; i < 4; i++) begin
                temp_digit_reg[i] <= temp_digit_next[i];
            end
            chime_reg <= chime_next;
            led_reg   <= led_next;
            scan_reg  <= scan_next;
            mode_reg  <= mode_next;
            pause_reg <= pause_next;
        end
    end

endmodule

### tb/tb.sv
// Self-checking bench for clock_with_chime_and_segment_scan: timekeeping, chime, set-time
// errors, display mode and digit scan are predicted in the bench and checked beat by beat.
// Depends on ccs_pkg and the clock_with_chime_and_segment_scan RTL.
module tb;

    localparam int ITEM_TARGET   = 1700;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SHOW_LIMIT    = 10;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 300;

    // Operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Segment patterns of the sixteen digit codes, bit 7 clear
    localparam logic [7:0] DIGIT_GLYPH [16] = '{
        8'h5F, 8'h06, 8'h3B, 8'h2F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h59, 8'h3E, 8'h79, 8'h71
    };

    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ccs_pkg::in_beat_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ccs_pkg::out_beat_t m_data;

    clock_with_chime_and_segment_scan dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Commands waiting to be sent and readouts waiting to arrive
    ccs_pkg::in_beat_t  clock_cmds[$];
    ccs_pkg::out_beat_t readouts_due[$];
    int        planned_work = 0;
    int        mismatches   = 0;
    int        readouts_seen = 0;

    // Mirror of the clock, chime and display state
    logic [4:0]  clk_hours;
    logic [5:0]  clk_minutes;
    logic [5:0]  clk_seconds;
    logic [11:0] shown_hhmm;
    logic [3:0]  temp_digit [4];
    logic [4:0]  chimes_left;
    logic        led_lit;
    logic [1:0]  scan_slot;
    logic        temp_mode;
    logic        halted;

    task automatic reset_mirror();
        clk_hours   = 5'd11;
        clk_minutes = 6'd59;
        clk_seconds = 6'd50;
        shown_hhmm  = '0;
        for (int k = 0; k < 4; k++) temp_digit[k] = '0;
        chimes_left = '0;
        led_lit     = 1'b0;
        scan_slot   = '0;
        temp_mode   = 1'b0;
        halted      = 1'b0;
    endtask

    // Clamp to 0..99.9 degrees and split into C glyph, tenths, ones, tens
    function automatic void latch_temperature(input logic [11:0] raw);
        int t;
        t = int'($signed(raw));
        if (t < 0) t = 0;
        if (t > 999) t = 999;
        temp_digit[0] = ccs_pkg::GLYPH_C;
        temp_digit[1] = 4'(t % 10);
        temp_digit[2] = 4'((t / 10) % 10);
        temp_digit[3] = 4'(t / 100);
    endfunction

    // Apply one command to the mirror and return the readout it should produce
    function automatic ccs_pkg::out_beat_t predict_readout(input ccs_pkg::in_beat_t b);
        ccs_pkg::out_beat_t r;
        int        v;
        r = '0;
        case (b.operation)
            ccs_pkg::OP_SECOND_TICK: begin
                if (!halted) begin
                    if (clk_seconds == ccs_pkg::MAX_SECOND) begin
                        clk_seconds = '0;
                        if (clk_minutes == ccs_pkg::MAX_MINUTE) begin
                            clk_minutes = '0;
                            clk_hours = (clk_hours == ccs_pkg::MAX_HOUR) ? 5'd0
                                                                         : clk_hours + 5'd1;
                            if (clk_hours > ccs_pkg::NOON_HOUR)
                                chimes_left = 5'((clk_hours - ccs_pkg::NOON_HOUR) * 2);
                            else if (clk_hours == 5'd0)
                                chimes_left = ccs_pkg::MIDNIGHT_CHIMES;
                            else
                                chimes_left = 5'(clk_hours * 2);
                        end else begin
                            clk_minutes = clk_minutes + 6'd1;
                        end
                    end else begin
                        clk_seconds = clk_seconds + 6'd1;
                    end
                    shown_hhmm = 12'(int'(clk_hours) * 100 + int'(clk_minutes));
                    if (temp_mode) latch_temperature(b.temperature_tenths);
                end
                // chime runs even while halted
                if (chimes_left != '0) begin
                    led_lit = ~led_lit;
                    chimes_left = chimes_left - 5'd1;
                end
            end
            ccs_pkg::OP_SCAN_TICK: begin
                if (!temp_mode) begin
                    v = int'(shown_hhmm);
                    for (int k = 0; k < int'(scan_slot); k++) v = v / 10;
                    r.segments = DIGIT_GLYPH[v % 10];
                    if (scan_slot == 2'd2 && !clk_seconds[0])
                        r.segments = r.segments ^ ccs_pkg::SEG_DOT;
                end else begin
                    r.segments = DIGIT_GLYPH[temp_digit[scan_slot]];
                    if (scan_slot == 2'd3) r.segments = r.segments | ccs_pkg::SEG_DOT;
                end
                r.digit_select = 4'b1000 >> scan_slot;
                scan_slot = scan_slot + 2'd1;
            end
            ccs_pkg::OP_PAUSE: halted = 1'b1;
            ccs_pkg::OP_SET_TIME: begin
                if (halted) begin
                    clk_hours = '0;
                    clk_minutes = '0;
                    clk_seconds = '0;
                    if (b.new_hours > 7'(ccs_pkg::MAX_HOUR)) begin
                        r.set_error = ccs_pkg::ERR_HOURS;
                    end else begin
                        clk_hours = 5'(b.new_hours);
                        if (b.new_minutes > 7'(ccs_pkg::MAX_MINUTE)) begin
                            r.set_error = ccs_pkg::ERR_MINUTES;
                        end else begin
                            clk_minutes = 6'(b.new_minutes);
                            if (b.new_seconds > 7'(ccs_pkg::MAX_SECOND)) begin
                                r.set_error = ccs_pkg::ERR_SECONDS;
                            end else begin
                                clk_seconds = 6'(b.new_seconds);
                                halted = 1'b0;
                            end
                        end
                    end
                end
            end
            ccs_pkg::OP_TOGGLE_MODE: begin
                temp_mode = ~temp_mode;
                if (temp_mode) latch_temperature(b.temperature_tenths);
            end
            default: ;
        endcase
        r.led_on           = led_lit;
        r.hours            = clk_hours;
        r.minutes          = clk_minutes;
        r.seconds          = clk_seconds;
        r.show_temperature = temp_mode;
        r.paused           = halted;
        return r;
    endfunction

    // Command builders; fields a command does not use stay random
    function automatic ccs_pkg::in_beat_t cmd(input logic [2:0] op);
        ccs_pkg::in_beat_t b;
        b.operation          = op;
        b.new_hours          = 7'($urandom);
        b.new_minutes        = 7'($urandom);
        b.new_seconds        = 7'($urandom);
        b.temperature_tenths = 12'($urandom);
        return b;
    endfunction

    function automatic ccs_pkg::in_beat_t set_cmd(input int h, input int m, input int s);
        ccs_pkg::in_beat_t b;
        b = cmd(ccs_pkg::OP_SET_TIME);
        b.new_hours   = 7'(h);
        b.new_minutes = 7'(m);
        b.new_seconds = 7'(s);
        return b;
    endfunction

    function automatic ccs_pkg::in_beat_t toggle_cmd(input int temp);
        ccs_pkg::in_beat_t b;
        b = cmd(ccs_pkg::OP_TOGGLE_MODE);
        b.temperature_tenths = 12'(temp);
        return b;
    endfunction

    function automatic int rand_temp();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) return int'($signed(12'($urandom)));
        if (pick == 1) return -int'($urandom_range(1, 2048));
        return int'($urandom_range(0, 999));
    endfunction

    task automatic plan(input ccs_pkg::in_beat_t b);
        clock_cmds.push_back(b);
        if (b.operation <= ccs_pkg::OP_TOGGLE_MODE) planned_work++;
    endtask

    // Stimulus: directed corner cases, then random command sequences
    initial begin : stimulus
        int kind, n, h, m, s, pick;
        repeat (4) plan(cmd(ccs_pkg::OP_SCAN_TICK));
        plan(cmd(ccs_pkg::OP_SECOND_TICK));
        repeat (2) plan(cmd(ccs_pkg::OP_SCAN_TICK));
        plan(set_cmd(5, 5, 5));                 // ignored while running
        repeat (2) plan(cmd(ccs_pkg::OP_PAUSE));
        plan(set_cmd(127, 127, 127));
        plan(set_cmd(23, 60, 0));
        plan(set_cmd(23, 59, 127));
        plan(set_cmd(23, 59, 59));
        plan(cmd(ccs_pkg::OP_SECOND_TICK));     // midnight, full chime
        plan(cmd(ccs_pkg::OP_PAUSE));
        plan(set_cmd(11, 59, 59));
        plan(cmd(ccs_pkg::OP_SECOND_TICK));     // noon
        plan(toggle_cmd(-2048));
        repeat (4) plan(cmd(ccs_pkg::OP_SCAN_TICK));
        plan(toggle_cmd(0));
        plan(toggle_cmd(2047));
        plan(cmd(ccs_pkg::OP_SECOND_TICK));
        plan(cmd(OP_SPARE_5));
        plan(cmd(OP_SPARE_6));
        plan(cmd(OP_SPARE_7));

        while (planned_work < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    // valid set close to a rollover, then let it run
                    h = $urandom_range(0, 23);
                    m = ($urandom_range(0, 9) < 7) ? 59 : $urandom_range(0, 59);
                    s = $urandom_range(40, 59);
                    plan(cmd(ccs_pkg::OP_PAUSE));
                    plan(set_cmd(h, m, s));
                    n = $urandom_range(10, 40);
                    repeat (n) begin
                        pick = $urandom_range(0, 19);
                        if (pick < 12)      plan(cmd(ccs_pkg::OP_SECOND_TICK));
                        else if (pick < 18) plan(cmd(ccs_pkg::OP_SCAN_TICK));
                        else if (pick < 19) plan(toggle_cmd(rand_temp()));
                        else                plan(cmd(ccs_pkg::OP_PAUSE));
                    end
                end
                4, 5: begin
                    n = $urandom_range(4, 12);
                    repeat (n) plan(cmd(ccs_pkg::OP_SCAN_TICK));
                    if ($urandom_range(0, 1)) plan(toggle_cmd(rand_temp()));
                end
                6: begin
                    // one bad field; earlier fields valid
                    plan(cmd(ccs_pkg::OP_PAUSE));
                    h = $urandom_range(0, 23);
                    m = $urandom_range(0, 59);
                    s = $urandom_range(0, 59);
                    case ($urandom_range(0, 2))
                        0:       h = $urandom_range(24, 127);
                        1:       m = $urandom_range(60, 127);
                        default: s = $urandom_range(60, 127);
                    endcase
                    plan(set_cmd(h, m, s));
                    repeat ($urandom_range(1, 6)) plan(cmd(ccs_pkg::OP_SECOND_TICK));
                end
                7: begin
                    repeat ($urandom_range(3, 10)) plan(cmd(3'($urandom)));
                end
                8: begin
                    // toggle display mode, then ticks; second ticks reload the temperature while it is shown
                    plan(toggle_cmd(rand_temp()));
                    n = $urandom_range(5, 20);
                    repeat (n) begin
                        if ($urandom_range(0, 2) == 0) plan(cmd(ccs_pkg::OP_SCAN_TICK));
                        else plan(cmd(ccs_pkg::OP_SECOND_TICK));
                    end
                    plan(toggle_cmd(rand_temp()));
                end
                default: begin
                    repeat ($urandom_range(20, 80)) plan(cmd(ccs_pkg::OP_SECOND_TICK));
                end
            endcase
        end
    end

    // Sender: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            reset_mirror();
        end else begin
            if (s_valid && s_ready) readouts_due.push_back(predict_readout(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (clock_cmds.size() != 0) begin
                    s_data  <= clock_cmds.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 7))
                            0, 1, 2: gap_left = 0;
                            7:       gap_left = $urandom_range(12, 40);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall style is re-drawn whenever its countdown runs out; one long hold-off
    rx_style_t rx_style   = RX_STEADY;
    int        style_left = 0;
    int        hold_left  = 0;
    logic      hold_done  = 1'b0;
    logic [7:0] rx_count  = '0;

    always @(posedge aclk) begin
        rx_count <= rx_count + 8'd1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && readouts_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   <= rx_style_t'($urandom_range(0, 3));
                style_left <= $urandom_range(16, 96);
            end else begin
                style_left <= style_left - 1;
            end
            case (rx_style)
                RX_STEADY:   m_ready <= 1'b1;
                RX_LIGHT:    m_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:    m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= (rx_count[2:0] < 3'd5);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    // Monitor: compare each readout beat with the oldest prediction
    always @(posedge aclk) begin : monitor
        ccs_pkg::out_beat_t want;
        string     diff;
        if (aresetn && m_valid && m_ready) begin
            readouts_seen <= readouts_seen + 1;
            if (readouts_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= SHOW_LIMIT)
                    $display("readout %0d with nothing predicted: got %h", readouts_seen, m_data);
            end else begin
                want = readouts_due.pop_front();
                diff = "";
                if (m_data.segments !== want.segments)         diff = {diff, " segments"};
                if (m_data.digit_select !== want.digit_select) diff = {diff, " digit_select"};
                if (m_data.led_on !== want.led_on)             diff = {diff, " led_on"};
                if (m_data.hours !== want.hours)               diff = {diff, " hours"};
                if (m_data.minutes !== want.minutes)           diff = {diff, " minutes"};
                if (m_data.seconds !== want.seconds)           diff = {diff, " seconds"};
                if (m_data.set_error !== want.set_error)       diff = {diff, " set_error"};
                if (m_data.show_temperature !== want.show_temperature)
                    diff = {diff, " show_temperature"};
                if (m_data.paused !== want.paused)             diff = {diff, " paused"};
                if (diff != "") begin
                    mismatches = mismatches + 1;
                    if (mismatches <= SHOW_LIMIT)
                        $display("readout %0d bad field(s):%s  expected %h  actual %h",
                                 readouts_seen, diff, want, m_data);
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either channel
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // End of run: all commands sent, all readouts in, then a short drain
    initial begin : wrap_up
        wait (aresetn);
        @(negedge aclk);
        while (clock_cmds.size() != 0 || s_valid || readouts_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && readouts_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
src/ccs_pkg.sv
src/ccs_temp_digits.sv
src/clock_with_chime_and_segment_scan.sv
tb/tb.sv
